FILE: sv/srq_pkg.sv
`timescale 1ns / 1ps
// Package for the sequence reorder queue: sizes, request codes, sequencer states
// and the record type kept per ring slot. No dependencies.
package srq_pkg;

   localparam int Depth     = 64;
   localparam int SlotBits  = $clog2(Depth);
   localparam int CountBits = $clog2(Depth + 1);
   localparam int TagBits   = 16;
   localparam int SeqBits   = 64;
   localparam int LenBits   = 32;
   localparam int TotalBits = 39;
   localparam int RdyBits   = 38;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_FINAL = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_LEFT,
      ST_RD_RIGHT,
      ST_WR_SLOT,
      ST_WR_START,
      ST_WR_END,
      ST_POP_RD,
      ST_POP_WR,
      ST_POP_TAIL,
      ST_STATUS,
      ST_STATUS_RD,
      ST_DONE
   } state_type;

   // One slot record: payload plus span bookkeeping.
   typedef struct packed {
      logic [TagBits-1:0]   tag;
      logic [LenBits-1:0]   len;
      logic [SeqBits-1:0]   first;
      logic [SeqBits-1:0]   last;
      logic [CountBits-1:0] items;
      logic [TotalBits-1:0] total;
   } slot_rec_type;

   // Per-field write enables of a slot record, in record order.
   typedef struct packed {
      logic tag;
      logic len;
      logic first;
      logic last;
      logic items;
      logic total;
   } rec_sel_type;

   // Whole record, span start fields, span end fields, span fields, counts only.
   localparam rec_sel_type SelAll   = 6'b111111;
   localparam rec_sel_type SelStart = 6'b000111;
   localparam rec_sel_type SelEnd   = 6'b001011;
   localparam rec_sel_type SelSpan  = 6'b001111;
   localparam rec_sel_type SelCount = 6'b000011;

   // Memory access command from the sequencer.
   typedef struct packed {
      logic                rd_en;
      logic [SlotBits-1:0] rd_addr;
      logic                wr_en;
      logic [SlotBits-1:0] wr_addr;
      rec_sel_type         wr_sel;
      slot_rec_type        wr_data;
   } mem_cmd_type;

endpackage

FILE: sv/sequence_reorder_queue_core.sv
`timescale 1ns / 1ps
// Sequence reorder queue: a 64-slot reorder window that takes numbered items in any
// order and hands them out in sequence order. The input is stalled for the whole
// transaction, until the result has been taken. All slot records sit in one memory
// with one write and one registered read port, so each read of a neighbor and each
// span record update takes its own sequencer state.
// Uses srq_pkg and srq_slot_mem.
module sequence_reorder_queue_core
   import srq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic [SeqBits-1:0]  req_seq_num,
   input  logic [LenBits-1:0]  req_byte_count,
   input  logic [TagBits-1:0]  req_item_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [TagBits-1:0]  rsp_out_tag,
   output logic [SeqBits-1:0]  rsp_out_seq,
   output logic [LenBits-1:0]  rsp_out_bytes,
   output logic [6:0]          rsp_ready_items,
   output logic [RdyBits-1:0]  rsp_ready_bytes,
   output logic [SeqBits-1:0]  rsp_current_length,
   output logic                rsp_expecting_more,
   output logic                rsp_queue_dead,
   output logic                rsp_queue_empty,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SeqBits-1:0]  csr_initial_sequence
);

   state_type state_ff, state_in;

   // Control registers.
   logic [SeqBits-1:0]   head_seq_ff, head_seq_in;
   logic [SlotBits-1:0]  head_slot_ff, head_slot_in;
   logic [CountBits-1:0] held_ff, held_in;
   logic [CountBits-1:0] extent_ff, extent_in;
   logic                 final_known_ff, final_known_in;
   logic [SeqBits-1:0]   final_len_ff, final_len_in;
   logic [Depth-1:0]     full_ff, full_in;

   // Transaction context.
   logic [1:0]           op_ff;
   logic [SeqBits-1:0]   seq_ff;
   logic [LenBits-1:0]   len_ff;
   logic [TagBits-1:0]   tag_ff;
   logic [CountBits-1:0] off_ff, off_in;
   slot_rec_type         rec_ff, rec_in;
   logic                 ok_ff, ok_in;
   logic [TagBits-1:0]   otag_ff, otag_in;
   logic [SeqBits-1:0]   oseq_ff, oseq_in;
   logic [LenBits-1:0]   olen_ff, olen_in;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 has_next_ff;

   mem_cmd_type  cmd;
   slot_rec_type rd_data;

   srq_slot_mem u_mem (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   // Slot address for an offset from the head.
   function automatic logic [SlotBits-1:0] slot_at(
      input logic [SlotBits-1:0] hs, input logic [SeqBits-1:0] off);
      slot_at = hs + off[SlotBits-1:0];
   endfunction

   // Shared offset arithmetic.
   logic [SeqBits-1:0]   diff;
   logic                 late;
   logic [CountBits-1:0] off_n;
   logic [SlotBits-1:0]  slot_cur, slot_left, slot_right, slot_next, slot_st, slot_en;
   logic [SeqBits-1:0]   tail_off;
   logic                 left_full, right_full;
   logic                 accept_req;

   assign accept_req = req_valid && !req_stall;
   assign diff       = seq_ff - head_seq_ff;
   assign late       = seq_ff < head_seq_ff;
   assign off_n      = diff[CountBits-1:0];
   assign slot_cur   = slot_at(head_slot_ff, {{(SeqBits-CountBits){1'b0}}, off_ff});
   assign slot_left  = slot_cur - 1'b1;
   assign slot_right = slot_cur + 1'b1;
   assign slot_next  = head_slot_ff + 1'b1;
   assign left_full  = (off_ff != '0) && full_ff[slot_left];
   assign right_full = ({1'b0, off_ff} + 1'b1 < {1'b0, extent_ff}) && full_ff[slot_right];
   assign slot_st    = (rec_ff.first <= head_seq_ff) ? head_slot_ff
                       : slot_at(head_slot_ff, rec_ff.first - head_seq_ff);
   assign slot_en    = slot_at(head_slot_ff, rec_ff.last - head_seq_ff);
   assign tail_off   = rec_ff.last - head_seq_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               state_in = ST_STATUS;
               if (req_type == REQ_PUSH) state_in = ST_RD_LEFT;
               if (req_type == REQ_POP)  state_in = ST_POP_RD;
            end
         end
         ST_RD_LEFT: begin
            state_in = ST_STATUS;
            if (!late && diff < Depth) begin
               if (off_n < extent_ff) begin
                  if (!full_ff[slot_at(head_slot_ff, diff)]) state_in = ST_RD_RIGHT;
               end else if (!final_known_ff && seq_ff != '1) begin
                  state_in = ST_RD_RIGHT;
               end
            end
         end
         ST_RD_RIGHT: state_in = ST_WR_SLOT;
         ST_WR_SLOT:  state_in = ST_WR_START;
         ST_WR_START: state_in = ST_WR_END;
         ST_WR_END:   state_in = ST_STATUS;
         ST_POP_RD: begin
            state_in = (extent_ff != '0 && full_ff[head_slot_ff]) ? ST_POP_WR : ST_STATUS;
         end
         ST_POP_WR:    state_in = ST_POP_TAIL;
         ST_POP_TAIL:  state_in = ST_STATUS;
         ST_STATUS:    state_in = ST_STATUS_RD;
         ST_STATUS_RD: state_in = ST_DONE;
         ST_DONE:      state_in = rsp_stall ? ST_DONE : ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory commands per state.
   always_comb begin
      head_seq_in    = head_seq_ff;
      head_slot_in   = head_slot_ff;
      held_in        = held_ff;
      extent_in      = extent_ff;
      final_known_in = final_known_ff;
      final_len_in   = final_len_ff;
      full_in        = full_ff;
      off_in         = off_ff;
      rec_in         = rec_ff;
      ok_in          = ok_ff;
      otag_in        = otag_ff;
      oseq_in        = oseq_ff;
      olen_in        = olen_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               ok_in   = 1'b0;
               otag_in = '0;
               oseq_in = '0;
               olen_in = '0;
            end
            if (csr_valid && held_ff == '0) head_seq_in = csr_initial_sequence;
         end
         ST_RD_LEFT: begin
            // Validate, latch offset, fetch left neighbor.
            off_in = off_n;
            if (!late && diff < Depth && off_n >= extent_ff && !final_known_ff
                && seq_ff != '1) begin
               extent_in = off_n + 1'b1;
            end
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = slot_at(head_slot_ff, diff) - 1'b1;
            rec_in.tag   = tag_ff;
            rec_in.len   = len_ff;
            rec_in.first = seq_ff;
            rec_in.last  = seq_ff;
            rec_in.items = CountBits'(1);
            rec_in.total = TotalBits'(len_ff);
         end
         ST_RD_RIGHT: begin
            if (left_full) begin
               rec_in.first = rd_data.first;
               rec_in.items = rec_ff.items + rd_data.items;
               rec_in.total = rec_ff.total + rd_data.total;
            end
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = slot_right;
         end
         ST_WR_SLOT: begin
            if (right_full) begin
               rec_in.last  = rd_data.last;
               rec_in.items = rec_ff.items + rd_data.items;
               rec_in.total = rec_ff.total + rd_data.total;
            end
         end
         ST_WR_START: begin
            // The slot itself gets the whole record.
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = slot_cur;
            cmd.wr_sel  = SelAll;
            cmd.wr_data = rec_ff;
            full_in[slot_cur] = 1'b1;
            held_in = held_ff + 1'b1;
            ok_in   = 1'b1;
         end
         ST_WR_END: begin
            // Span start keeps its payload and first field.
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = slot_st;
            cmd.wr_sel  = SelStart;
            cmd.wr_data = rec_ff;
         end
         ST_POP_RD: begin
            if (extent_ff != '0 && full_ff[head_slot_ff]) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = head_slot_ff;
            end
         end
         ST_POP_WR: begin
            ok_in   = 1'b1;
            otag_in = rd_data.tag;
            oseq_in = head_seq_ff;
            olen_in = rd_data.len;
            rec_in  = rd_data;
            rec_in.items = rd_data.items - 1'b1;
            rec_in.total = rd_data.total - TotalBits'(rd_data.len);
            // Hand the span record on to the next slot, keeping its payload.
            if (extent_ff > 1 && full_ff[slot_next]) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = slot_next;
               cmd.wr_sel  = SelSpan;
               cmd.wr_data.first = rd_data.first;
               cmd.wr_data.last  = rd_data.last;
               cmd.wr_data.items = rd_data.items - 1'b1;
               cmd.wr_data.total = rd_data.total - TotalBits'(rd_data.len);
            end
            off_in = (extent_ff > 1 && full_ff[slot_next]) ? CountBits'(1) : '0;
         end
         ST_POP_TAIL: begin
            // Keep the span end counts in step, measured from the old head.
            if (off_ff != '0 && tail_off > 1 && tail_off < extent_ff) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = slot_at(head_slot_ff, tail_off);
               cmd.wr_sel  = SelCount;
               cmd.wr_data = rec_ff;
            end
            full_in[head_slot_ff] = 1'b0;
            held_in      = held_ff - 1'b1;
            head_seq_in  = head_seq_ff + 1'b1;
            head_slot_in = slot_next;
            extent_in    = extent_ff - 1'b1;
         end
         ST_STATUS: begin
            if (op_ff == REQ_FINAL && !final_known_ff && !(seq_ff < head_seq_ff)
                && !(diff < extent_ff) && !(diff > Depth)) begin
               final_known_in = 1'b1;
               final_len_in   = seq_ff;
               extent_in      = diff[CountBits-1:0];
               ok_in          = 1'b1;
            end
            // Span end of a placed push keeps its payload and last field.
            if (op_ff == REQ_PUSH && ok_ff) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = slot_en;
               cmd.wr_sel  = SelEnd;
               cmd.wr_data = rec_ff;
            end
         end
         ST_STATUS_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = head_slot_ff;
         end
         default: ;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_seq_ff    <= '0;
         head_slot_ff   <= '0;
         held_ff        <= '0;
         extent_ff      <= '0;
         final_known_ff <= 1'b0;
         final_len_ff   <= '0;
         full_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_seq_ff    <= head_seq_in;
         head_slot_ff   <= head_slot_in;
         held_ff        <= held_in;
         extent_ff      <= extent_in;
         final_known_ff <= final_known_in;
         final_len_ff   <= final_len_in;
         full_ff        <= full_in;
         rsp_valid_ff   <= (state_ff == ST_STATUS_RD) ||
                           (rsp_valid_ff && rsp_stall);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept_req) begin
         op_ff  <= req_type;
         seq_ff <= req_seq_num;
         len_ff <= req_byte_count;
         tag_ff <= req_item_tag;
      end
      off_ff  <= off_in;
      rec_ff  <= rec_in;
      ok_ff   <= ok_in;
      otag_ff <= otag_in;
      oseq_ff <= oseq_in;
      olen_ff <= olen_in;
      if (state_ff == ST_STATUS_RD) begin
         has_next_ff <= extent_ff != '0 && full_ff[head_slot_ff];
      end
   end

   // Status taken from the head record as it arrives in the response cycle.
   logic [CountBits-1:0] items_v;
   logic [TotalBits-1:0] total_v;
   logic                 expecting;
   logic [SeqBits-1:0]   remain;

   assign items_v   = has_next_ff ? rd_data.items : '0;
   assign total_v   = has_next_ff ? rd_data.total : '0;
   assign remain    = final_len_ff - head_seq_ff;
   assign expecting = !final_known_ff ? 1'b1
                      : (head_seq_ff >= final_len_ff) ? 1'b0
                      : ({{(SeqBits-CountBits){1'b0}}, held_ff} < remain);

   assign req_stall          = (state_ff != ST_IDLE);
   assign csr_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_out_tag        = otag_ff;
   assign rsp_out_seq        = oseq_ff;
   assign rsp_out_bytes      = olen_ff;
   assign rsp_ready_items    = items_v;
   assign rsp_ready_bytes    = total_v[RdyBits-1:0];
   assign rsp_current_length = head_seq_ff + {{(SeqBits-CountBits){1'b0}}, items_v};
   assign rsp_expecting_more = expecting;
   assign rsp_queue_dead     = !has_next_ff && !expecting;
   assign rsp_queue_empty    = held_ff == '0;

   // Checks on the sequencer's own bookkeeping.
   assert property (@(posedge clock) disable iff (reset)
      held_ff <= Depth) else $error("held count above depth");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_DONE || state_ff == ST_IDLE)
      else $error("response outside done state");
   assert property (@(posedge clock) disable iff (reset)
      extent_ff <= Depth) else $error("window extent above depth");
   assert property (@(posedge clock) disable iff (reset)
      $countones(full_ff) == held_ff) else $error("full bits disagree with count");

endmodule

FILE: sv/srq_slot_mem.sv
`timescale 1ns / 1ps
// Slot record memory: one write port with per-field enables, one registered read port.
// Depends on srq_pkg.
module srq_slot_mem
   import srq_pkg::*;
(
   input  logic         clock,
   input  mem_cmd_type  cmd,
   output slot_rec_type rd_data
);

   slot_rec_type mem [Depth];
   slot_rec_type rd_data_ff;

   // Write the selected fields and read in one clocked block; read data is registered.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         if (cmd.wr_sel.tag)   mem[cmd.wr_addr].tag   <= cmd.wr_data.tag;
         if (cmd.wr_sel.len)   mem[cmd.wr_addr].len   <= cmd.wr_data.len;
         if (cmd.wr_sel.first) mem[cmd.wr_addr].first <= cmd.wr_data.first;
         if (cmd.wr_sel.last)  mem[cmd.wr_addr].last  <= cmd.wr_data.last;
         if (cmd.wr_sel.items) mem[cmd.wr_addr].items <= cmd.wr_data.items;
         if (cmd.wr_sel.total) mem[cmd.wr_addr].total <= cmd.wr_data.total;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
